// File: hw/rtl/dja_pkg.sv
// Shared constants, types and helper functions of the de Jong attractor density core.
package dja_pkg;

  localparam int GRID_SIZE_DEF  = 800;
  localparam int SINE_DEPTH_DEF = 1024;

  localparam int COORD_W   = 10;
  localparam int CNT_W     = 16;
  localparam int PT_W      = 19;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 2;
  localparam int SIN_W     = 18;
  localparam int ADDR_W    = 20;

  localparam int          TWO_PI_Q16 = 411775;
  localparam logic [63:0] PI_Q30     = 64'd3373259426;

  localparam logic [CNT_W-1:0] CNT_LIMIT = 16'd64880;
  localparam logic [CNT_W-1:0] CNT_STEP  = 16'd655;
  localparam logic [CNT_W-1:0] SHADE_MAX = 16'hFFFF;
  localparam int               CELL_SCALE  = 160;
  localparam int               CELL_OFFSET = 400;

  localparam int QUEUE_DEPTH = 2;

  // Divisors (2n)(2n+1) of the odd Taylor terms of the sine.
  localparam longint TAYLOR_DIV [1:12] = '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420, 506,
                                           600};

  typedef enum logic [CMD_W-1:0] {
    CMD_ITER    = 2'd0,
    CMD_READ    = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_A = 2'd0,
    CFG_COEF_B = 2'd1,
    CFG_COEF_C = 2'd2,
    CFG_COEF_D = 2'd3
  } cfg_e;

  typedef enum logic [1:0] {
    OP_ITER,
    OP_READ,
    OP_ZERO,
    OP_RESTART
  } op_e;

  typedef struct packed {
    op_e                      op;
    logic [COORD_W-1:0]       col;
    logic [COORD_W-1:0]       row;
    logic [ADDR_W-1:0]        addr;
    logic signed [PT_W-1:0]   seed_x;
    logic signed [PT_W-1:0]   seed_y;
  } qent_t;

  typedef struct packed {
    logic                   valid;
    logic [1:0]             id;
    logic                   is_cos;
    logic signed [PT_W-1:0] coef;
    logic signed [PT_W-1:0] pt;
  } ang_req_t;

  typedef struct packed {
    logic                    valid;
    logic [1:0]              id;
    logic signed [SIN_W-1:0] value;
  } ang_rsp_t;

  function automatic logic [ADDR_W-1:0] cell_addr(logic [COORD_W-1:0] col,
                                                  logic [COORD_W-1:0] row, int grid);
    return ADDR_W'(int'(col) * grid + int'(row));
  endfunction

  // floor(v * 160 / 65536) + 400, held to the grid.
  function automatic logic [COORD_W-1:0] to_cell(logic signed [PT_W-1:0] v, int grid);
    logic signed [26:0] t;
    logic signed [11:0] c;
    t = 27'(v) * 27'(CELL_SCALE);
    c = 12'($signed(t[26:16])) + 12'(CELL_OFFSET);
    if (c < 0) return '0;
    if (int'(c) > grid - 1) return COORD_W'(grid - 1);
    return c[COORD_W-1:0];
  endfunction

endpackage

// File: hw/rtl/dja_front.sv
// Front end: takes input words and classifies them into queue entries.
module dja_front
  import dja_pkg::*;
#(
  parameter int GRID_SIZE = GRID_SIZE_DEF
) (
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [CMD_W-1:0]       command_i,
  input  logic [COORD_W-1:0]     read_col_i,
  input  logic [COORD_W-1:0]     read_row_i,
  input  logic signed [PT_W-1:0] seed_x_i,
  input  logic signed [PT_W-1:0] seed_y_i,
  input  logic                   q_full_i,
  input  logic                   clearing_i,
  output logic                   q_push_o,
  output qent_t                  q_entry_o
);

  logic in_range;

  assign in_ready_o = !q_full_i && !clearing_i;
  assign q_push_o   = in_valid_i && in_ready_o;
  assign in_range   = ({1'b0, read_col_i} < 11'(GRID_SIZE)) &&
                      ({1'b0, read_row_i} < 11'(GRID_SIZE));

  always_comb begin
    q_entry_o.op     = OP_ZERO;
    q_entry_o.col    = '0;
    q_entry_o.row    = '0;
    q_entry_o.addr   = cell_addr(read_col_i, read_row_i, GRID_SIZE);
    q_entry_o.seed_x = seed_x_i;
    q_entry_o.seed_y = seed_y_i;
    unique case (command_i)
      CMD_ITER: begin
        q_entry_o.op = OP_ITER;
      end
      CMD_READ: begin
        // An out-of-range read echoes the coordinates and returns an empty cell.
        q_entry_o.col = read_col_i;
        q_entry_o.row = read_row_i;
        q_entry_o.op  = in_range ? OP_READ : OP_ZERO;
      end
      CMD_RESTART: begin
        q_entry_o.op = OP_RESTART;
      end
      default: begin
        q_entry_o.op = OP_ZERO;
      end
    endcase
  end

endmodule

// File: hw/rtl/dja_queue.sv
// Short queue of classified commands between the front and back ends.
module dja_queue
  import dja_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  qent_t data_i,
  input  logic  pop_i,
  output logic  full_o,
  output logic  valid_o,
  output qent_t data_o
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  qent_t             entry_q [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  assign full_o  = (count_q == CntW'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: hw/rtl/dja_angle.sv
// Eight-stage trig unit: product, reduction modulo 2*pi, quantisation and quarter-wave lookup.
module dja_angle
  import dja_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  ang_req_t req_i,
  output ang_rsp_t rsp_o
);

  localparam int     PhaseN     = 4 * SINE_TABLE_DEPTH;
  localparam int     PW         = $clog2(PhaseN);
  localparam int     KW         = $clog2(5 * SINE_TABLE_DEPTH + 1);
  localparam int     AW         = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int     RecipShift = 24;
  localparam longint Recip      = (longint'(1) << RecipShift) * PhaseN / TWO_PI_Q16;
  localparam int     RW         = $clog2(Recip + 1);
  localparam int     MRW        = PT_W + RW;
  localparam longint NumMax     = longint'(TWO_PI_Q16) * (PhaseN + 1);
  localparam int     NW         = $clog2(NumMax);
  localparam longint HalfDiv    = 2 * SINE_TABLE_DEPTH;

  typedef logic [16:0] qtab_t [SINE_TABLE_DEPTH + 1];

  function automatic qtab_t build_qtab();
    qtab_t       tab;
    logic [63:0] th;
    logic [63:0] x2;
    logic [63:0] term;
    longint      s;
    int          j;
    int          n;
    for (j = 0; j <= SINE_TABLE_DEPTH; j++) begin
      th   = (64'(j) * PI_Q30 + 64'(SINE_TABLE_DEPTH)) / HalfDiv;
      x2   = (th * th) >> 30;
      term = th;
      s    = longint'(th);
      for (n = 1; n <= 12; n++) begin
        term = ((term * x2) >> 30) / TAYLOR_DIV[n];
        if (n[0]) s = s - longint'(term);
        else s = s + longint'(term);
      end
      if (s < 0) s = 0;
      s = (s + 8192) >>> 14;
      if (s > 65536) s = 65536;
      tab[j] = 17'(s);
    end
    return tab;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  logic [7:0]              vld_q;
  logic [1:0]              id_q [8];
  logic                    cos_q [4];
  logic                    neg_q [2];

  logic signed [37:0]      prod_q;
  logic [PT_W-1:0]         m_q, m3_q;
  logic [MRW-1:0]          mr_q;
  logic [KW-1:0]           qe_q;
  logic [NW-1:0]           qt_q, num_q;
  logic [PW-1:0]           k_q;
  logic [AW-1:0]           addr_q;
  logic [16:0]             rom_q;
  logic signed [SIN_W-1:0] val_q;

  logic signed [37:0]      prod_rnd;
  logic [21:0]             biased;
  logic [PT_W-1:0]         m_d;
  logic [MRW:0]            mr_rnd;
  logic [KW-1:0]           qe_d;
  logic [KW-1:0]           k_raw, k_off;
  logic [PW-1:0]           k_d;
  logic [PW-1:0]           r_d;
  logic [1:0]              quad_d;
  logic [AW-1:0]           addr_d;

  // Round the Q4.32 product to Q.16, then lift it positive by three turns and fold it back.
  always_comb begin
    prod_rnd = prod_q + 38'sd32768;
    biased   = 22'(23'($signed(prod_rnd[37:16])) + 23'(3 * TWO_PI_Q16));
    m_d      = PT_W'(biased);
    for (int i = 1; i <= 5; i++) begin
      if (biased >= 22'(i * TWO_PI_Q16)) begin
        m_d = PT_W'(biased - 22'(i * TWO_PI_Q16));
      end
    end
  end

  // The reciprocal estimate is at most one low; the remainder test corrects it.
  always_comb begin
    mr_rnd = {1'b0, mr_q} + (MRW + 1)'(longint'(1) << (RecipShift - 1));
    qe_d   = KW'(mr_rnd >> RecipShift);
    k_raw  = qe_q + KW'((num_q - qt_q) >= NW'(TWO_PI_Q16));
    if (k_raw >= KW'(PhaseN)) begin
      k_raw = k_raw - KW'(PhaseN);
    end
    k_off = cos_q[3] ? k_raw + KW'(SINE_TABLE_DEPTH) : k_raw;
    k_d   = (k_off >= KW'(PhaseN)) ? PW'(k_off - KW'(PhaseN)) : PW'(k_off);
  end

  always_comb begin
    if (k_q < PW'(SINE_TABLE_DEPTH)) begin
      quad_d = 2'd0;
      r_d    = k_q;
    end else if (k_q < PW'(2 * SINE_TABLE_DEPTH)) begin
      quad_d = 2'd1;
      r_d    = k_q - PW'(SINE_TABLE_DEPTH);
    end else if (k_q < PW'(3 * SINE_TABLE_DEPTH)) begin
      quad_d = 2'd2;
      r_d    = k_q - PW'(2 * SINE_TABLE_DEPTH);
    end else begin
      quad_d = 2'd3;
      r_d    = k_q - PW'(3 * SINE_TABLE_DEPTH);
    end
    addr_d = quad_d[0] ? AW'(SINE_TABLE_DEPTH) - AW'(r_d) : AW'(r_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[6:0], req_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    id_q[0]  <= req_i.id;
    cos_q[0] <= req_i.is_cos;
    for (int s = 1; s < 8; s++) begin
      id_q[s] <= id_q[s-1];
    end
    for (int s = 1; s < 4; s++) begin
      cos_q[s] <= cos_q[s-1];
    end
    prod_q   <= 38'(req_i.coef) * 38'(req_i.pt);
    m_q      <= m_d;
    mr_q     <= MRW'(m_q) * MRW'(Recip);
    m3_q     <= m_q;
    qe_q     <= qe_d;
    qt_q     <= NW'(qe_d) * NW'(TWO_PI_Q16);
    num_q    <= NW'(m3_q) * NW'(PhaseN) + NW'(TWO_PI_Q16 / 2);
    k_q      <= k_d;
    addr_q   <= addr_d;
    neg_q[0] <= quad_d[1];
    rom_q    <= QTAB[addr_q];
    neg_q[1] <= neg_q[0];
    val_q    <= neg_q[1] ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});
  end

  assign rsp_o.valid = vld_q[7];
  assign rsp_o.id    = id_q[7];
  assign rsp_o.value = val_q;

endmodule

// File: hw/rtl/dja_back.sv
// Back end: coefficient registers, point state, hit store and the command sequencer.
module dja_back
  import dja_pkg::*;
#(
  parameter int GRID_SIZE = GRID_SIZE_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [PT_W-1:0]        cfg_data_i,
  input  logic                   q_valid_i,
  input  qent_t                  q_entry_i,
  output logic                   q_pop_o,
  output ang_req_t               ang_req_o,
  input  ang_rsp_t               ang_rsp_i,
  output logic                   clearing_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [COORD_W-1:0]     cell_col_o,
  output logic [COORD_W-1:0]     cell_row_o,
  output logic [CNT_W-1:0]       density_o,
  output logic [CNT_W-1:0]       pen_shade_o,
  output logic signed [PT_W-1:0] next_x_o,
  output logic signed [PT_W-1:0] next_y_o
);

  localparam int Cells = GRID_SIZE * GRID_SIZE;
  localparam int AdrW  = $clog2(Cells);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ANGLE,
    S_SUM,
    S_CELL,
    S_ADDR,
    S_FETCH,
    S_USE,
    S_RESULT
  } state_e;

  state_e                  state_q;
  logic [AdrW-1:0]         clr_addr_q;
  logic                    boot_q;
  logic [2:0]              issue_q;
  logic [1:0]              recv_q;
  logic signed [SIN_W-1:0] sv_q [4];
  logic signed [PT_W-1:0]  coef_a_q, coef_b_q, coef_c_q, coef_d_q;
  logic signed [PT_W-1:0]  cur_x_q, cur_y_q;
  logic [COORD_W-1:0]      col_q, row_q;
  logic [AdrW-1:0]         addr_q;
  logic [CNT_W-1:0]        dens_q;
  logic                    is_iter_q;
  logic                    out_valid_q;
  logic [COORD_W-1:0]      out_col_q, out_row_q;
  logic [CNT_W-1:0]        out_dens_q, out_shade_q;
  logic signed [PT_W-1:0]  out_x_q, out_y_q;

  logic [CNT_W-1:0]        store_q [Cells];
  logic [CNT_W-1:0]        rdata_q;

  logic                    mem_we;
  logic [AdrW-1:0]         mem_waddr;
  logic [CNT_W-1:0]        mem_wdata;
  logic [CNT_W-1:0]        upd_cnt;
  logic [ADDR_W-1:0]       hit_addr;
  logic                    out_free;
  logic                    out_load;

  assign q_pop_o    = (state_q == S_IDLE) && q_valid_i;
  assign clearing_o = (state_q == S_CLEAR);
  assign out_free   = !out_valid_q || out_ready_i;
  assign out_load   = (state_q == S_RESULT) && out_free;
  assign upd_cnt    = (rdata_q < CNT_LIMIT) ? rdata_q + CNT_STEP : rdata_q;
  assign hit_addr   = cell_addr(col_q, row_q, GRID_SIZE);

  // The four angles go out in the order sin(a*y), cos(b*x), sin(c*x), cos(d*y).
  always_comb begin
    ang_req_o.valid = (state_q == S_ANGLE) && !issue_q[2];
    ang_req_o.id    = issue_q[1:0];
    ang_req_o.is_cos = issue_q[0];
    case (issue_q[1:0])
      2'd0:    begin ang_req_o.coef = coef_a_q; ang_req_o.pt = cur_y_q; end
      2'd1:    begin ang_req_o.coef = coef_b_q; ang_req_o.pt = cur_x_q; end
      2'd2:    begin ang_req_o.coef = coef_c_q; ang_req_o.pt = cur_x_q; end
      default: begin ang_req_o.coef = coef_d_q; ang_req_o.pt = cur_y_q; end
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = upd_cnt;
    if (state_q == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_q;
      mem_wdata = '0;
    end else if ((state_q == S_USE) && is_iter_q) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= store_q[addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_addr_q  <= '0;
      boot_q      <= 1'b1;
      issue_q     <= '0;
      recv_q      <= '0;
      for (int i = 0; i < 4; i++) begin
        sv_q[i] <= '0;
      end
      coef_a_q    <= 19'sd93005;
      coef_b_q    <= -19'sd149693;
      coef_c_q    <= 19'sd159091;
      coef_d_q    <= -19'sd143685;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      col_q       <= '0;
      row_q       <= '0;
      addr_q      <= '0;
      dens_q      <= '0;
      is_iter_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_dens_q  <= '0;
      out_shade_q <= SHADE_MAX;
      out_x_q     <= '0;
      out_y_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_COEF_A: coef_a_q <= $signed(cfg_data_i);
          CFG_COEF_B: coef_b_q <= $signed(cfg_data_i);
          CFG_COEF_C: coef_c_q <= $signed(cfg_data_i);
          CFG_COEF_D: coef_d_q <= $signed(cfg_data_i);
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (ang_rsp_i.valid) begin
        sv_q[ang_rsp_i.id] <= ang_rsp_i.value;
      end

      unique case (state_q)
        S_CLEAR: begin
          clr_addr_q <= clr_addr_q + 1'b1;
          if (clr_addr_q == AdrW'(Cells - 1)) begin
            state_q <= boot_q ? S_IDLE : S_RESULT;
          end
        end
        S_IDLE: begin
          if (q_valid_i) begin
            col_q     <= q_entry_i.col;
            row_q     <= q_entry_i.row;
            dens_q    <= '0;
            is_iter_q <= (q_entry_i.op == OP_ITER);
            unique case (q_entry_i.op)
              OP_ITER: begin
                issue_q <= '0;
                recv_q  <= '0;
                state_q <= S_ANGLE;
              end
              OP_READ: begin
                addr_q  <= q_entry_i.addr[AdrW-1:0];
                state_q <= S_FETCH;
              end
              OP_RESTART: begin
                cur_x_q    <= q_entry_i.seed_x;
                cur_y_q    <= q_entry_i.seed_y;
                clr_addr_q <= '0;
                boot_q     <= 1'b0;
                state_q    <= S_CLEAR;
              end
              default: begin
                state_q <= S_RESULT;
              end
            endcase
          end
        end
        S_ANGLE: begin
          if (!issue_q[2]) begin
            issue_q <= issue_q + 1'b1;
          end
          if (ang_rsp_i.valid) begin
            recv_q <= recv_q + 1'b1;
            if (recv_q == 2'd3) begin
              state_q <= S_SUM;
            end
          end
        end
        S_SUM: begin
          cur_x_q <= PT_W'(sv_q[0]) - PT_W'(sv_q[1]);
          cur_y_q <= PT_W'(sv_q[2]) - PT_W'(sv_q[3]);
          state_q <= S_CELL;
        end
        S_CELL: begin
          col_q   <= to_cell(cur_x_q, GRID_SIZE);
          row_q   <= to_cell(cur_y_q, GRID_SIZE);
          state_q <= S_ADDR;
        end
        S_ADDR: begin
          addr_q  <= hit_addr[AdrW-1:0];
          state_q <= S_FETCH;
        end
        S_FETCH: begin
          state_q <= S_USE;
        end
        S_USE: begin
          dens_q  <= is_iter_q ? upd_cnt : rdata_q;
          state_q <= S_RESULT;
        end
        S_RESULT: begin
          if (out_free) begin
            out_col_q   <= col_q;
            out_row_q   <= row_q;
            out_dens_q  <= dens_q;
            out_shade_q <= SHADE_MAX - dens_q;
            out_x_q     <= cur_x_q;
            out_y_q     <= cur_y_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign cell_col_o  = out_col_q;
  assign cell_row_o  = out_row_q;
  assign density_o   = out_dens_q;
  assign pen_shade_o = out_shade_q;
  assign next_x_o    = out_x_q;
  assign next_y_o    = out_y_q;

endmodule

// File: hw/rtl/de_jong_attractor_density_core.sv
// De Jong attractor density core: iterates x'=sin(a*y)-cos(b*x), y'=sin(c*x)-cos(d*y) in
// signed Q2.16 and counts hits in a GRID_SIZE x GRID_SIZE store of 16-bit cells. Commands
// pass through a two-word queue, so new words are taken while the back end works and while a
// result waits. An iterate sends the four angles one per cycle through the eight-stage trig
// unit, then does a read-modify-write of the store. A read fetches the cell from the store; a
// read outside the grid or an unused command goes straight to the result. After reset, and on
// every restart, the store is cleared one cell per cycle, GRID_SIZE*GRID_SIZE cells (640000
// at the default size); no input word is taken meanwhile, configuration writes are.
module de_jong_attractor_density_core
  import dja_pkg::*;
#(
  parameter int GRID_SIZE        = GRID_SIZE_DEF,
  parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [PT_W-1:0]        cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [CMD_W-1:0]       command_i,
  input  logic [COORD_W-1:0]     read_col_i,
  input  logic [COORD_W-1:0]     read_row_i,
  input  logic signed [PT_W-1:0] seed_x_i,
  input  logic signed [PT_W-1:0] seed_y_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [COORD_W-1:0]     cell_col_o,
  output logic [COORD_W-1:0]     cell_row_o,
  output logic [CNT_W-1:0]       density_o,
  output logic [CNT_W-1:0]       pen_shade_o,
  output logic signed [PT_W-1:0] next_x_o,
  output logic signed [PT_W-1:0] next_y_o
);

  logic     q_push, q_pop, q_full, q_valid, clearing;
  qent_t    q_wdata, q_rdata;
  ang_req_t ang_req;
  ang_rsp_t ang_rsp;

  dja_front #(
    .GRID_SIZE(GRID_SIZE)
  ) u_front (
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .command_i (command_i),
    .read_col_i(read_col_i),
    .read_row_i(read_row_i),
    .seed_x_i  (seed_x_i),
    .seed_y_i  (seed_y_i),
    .q_full_i  (q_full),
    .clearing_i(clearing),
    .q_push_o  (q_push),
    .q_entry_o (q_wdata)
  );

  dja_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .pop_i  (q_pop),
    .full_o (q_full),
    .valid_o(q_valid),
    .data_o (q_rdata)
  );

  dja_angle #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_angle (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (ang_req),
    .rsp_o (ang_rsp)
  );

  dja_back #(
    .GRID_SIZE(GRID_SIZE)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .q_valid_i  (q_valid),
    .q_entry_i  (q_rdata),
    .q_pop_o    (q_pop),
    .ang_req_o  (ang_req),
    .ang_rsp_i  (ang_rsp),
    .clearing_o (clearing),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cell_col_o (cell_col_o),
    .cell_row_o (cell_row_o),
    .density_o  (density_o),
    .pen_shade_o(pen_shade_o),
    .next_x_o   (next_x_o),
    .next_y_o   (next_y_o)
  );

endmodule
